/* sv/serial_frame_builder_core_defines.svh */
// assertion macros used by the frame builder back end
`ifndef SERIAL_FRAME_BUILDER_CORE_DEFINES_SVH
`define SERIAL_FRAME_BUILDER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SFB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/sfb_pkg.sv */
// types, constants and helper functions of the serial frame builder
package sfb_pkg;

	localparam int MAX_FLAG_BYTES      = 4;
	localparam int MAX_LEN_FIELD_BYTES = 4;
	localparam int LEN_WIDTH           = 16;

	localparam logic [31:0] LEN_MASK = 32'((64'd1 << LEN_WIDTH) - 64'd1);

	typedef logic [2:0] cfg_idx_t;

	localparam cfg_idx_t CFG_START_FLAG      = 3'd0;
	localparam cfg_idx_t CFG_START_FLAG_LEN  = 3'd1;
	localparam cfg_idx_t CFG_END_FLAG        = 3'd2;
	localparam cfg_idx_t CFG_END_FLAG_LEN    = 3'd3;
	localparam cfg_idx_t CFG_LEN_FIELD_BYTES = 3'd4;
	localparam cfg_idx_t CFG_LEN_BIG_ENDIAN  = 3'd5;
	localparam cfg_idx_t CFG_CHECKSUM_MODE   = 3'd6;

	typedef enum logic [1:0] {
		CK_NONE  = 2'd0,
		CK_SUM8  = 2'd1,
		CK_SUM16 = 2'd2,
		CK_XOR   = 2'd3
	} ck_mode_t;

	typedef struct packed {
		logic [31:0] start_flag;
		logic [2:0]  start_flag_len;
		logic [31:0] end_flag;
		logic [2:0]  end_flag_len;
		logic [2:0]  len_field_bytes;
		logic        len_big_endian;
		ck_mode_t    checksum_mode;
	} sfb_cfg_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] payload_len;
		logic        frame_last;
		logic        frame_first;
	} sfb_entry_t;

	function automatic logic [2:0] clamp_len(logic [2:0] v, int lim);
		logic [2:0] l;
		l = 3'(lim);
		return (v > l) ? l : v;
	endfunction

	function automatic logic [7:0] flag_byte(logic [31:0] flag, logic [2:0] i);
		logic [31:0] sh;
		sh = flag >> {i[1:0], 3'b000};
		return (i >= 3'd4) ? 8'h00 : sh[7:0];
	endfunction

	function automatic logic [7:0] len_byte(logic [15:0] plen, logic [2:0] k);
		logic [31:0] lv;
		logic [7:0]  b;
		lv = {16'h0000, plen} & LEN_MASK;
		case (k)
			3'd0: b = lv[7:0];
			3'd1: b = lv[15:8];
			3'd2: b = lv[23:16];
			3'd3: b = lv[31:24];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

/* sv/sfb_in_if.sv */
// payload word channel of the frame builder
interface sfb_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [15:0] payload_len;
	logic        frame_last;

	modport source(output valid, data_byte, payload_len, frame_last, input ready);
	modport sink(input valid, data_byte, payload_len, frame_last, output ready);
endinterface

/* sv/sfb_out_if.sv */
// framed word channel of the frame builder
interface sfb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_end;
	logic       len_mismatch;

	modport source(output valid, out_byte, run_last, frame_end, len_mismatch, input ready);
	modport sink(input valid, out_byte, run_last, frame_end, len_mismatch, output ready);
endinterface

/* sv/sfb_front.sv */
// front end: accepts payload words and marks the first word of each frame
module sfb_front (
	input  logic                clk,
	input  logic                arst_n,
	sfb_in_if.sink              payload,
	input  logic                full,
	output logic                push,
	output sfb_pkg::sfb_entry_t entry
);

	logic in_frame_q;

	assign payload.ready = !full;
	assign push          = payload.valid && !full;

	always_comb begin
		entry.data_byte   = payload.data_byte;
		entry.payload_len = payload.payload_len;
		entry.frame_last  = payload.frame_last;
		entry.frame_first = !in_frame_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (push) begin
			in_frame_q <= !payload.frame_last;
		end
	end

endmodule

/* sv/sfb_queue.sv */
// two-entry queue between front and back
module sfb_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sfb_pkg::sfb_entry_t entry_in,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output sfb_pkg::sfb_entry_t head
);

	sfb_pkg::sfb_entry_t entries_q [2];
	logic                wr_q;
	logic                rd_q;
	logic [1:0]          cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = entries_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* sv/sfb_back.sv */
// back end: sequences header, payload and trailer words, keeps checksum and count
`include "serial_frame_builder_core_defines.svh"

module sfb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sfb_pkg::sfb_cfg_t   cfg,
	input  logic                head_valid,
	input  sfb_pkg::sfb_entry_t head,
	output logic                pop,
	sfb_out_if.source           framed
);

	typedef enum logic [5:0] {
		PH_BEGIN = 6'b000001,
		PH_START = 6'b000010,
		PH_LEN   = 6'b000100,
		PH_DATA  = 6'b001000,
		PH_CHK   = 6'b010000,
		PH_END   = 6'b100000
	} phase_t;

	phase_t      phase_q;
	logic [2:0]  idx_q;
	logic [15:0] acc_q;
	logic [15:0] cnt_q;
	logic        mism_q;

	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        run_last_q;
	logic        frame_end_q;
	logic        len_mismatch_q;

	phase_t      eff;
	phase_t      nphase;
	logic [2:0]  nidx;
	logic [2:0]  idx_inc;
	logic [2:0]  sl;
	logic [2:0]  lb;
	logic [2:0]  el;
	logic [2:0]  len_k;
	logic [7:0]  cur_byte;
	logic        accum;
	logic        done;
	logic        frame_done;
	logic        load;
	logic [15:0] cnt_inc;
	logic        mism_now;
	logic [15:0] acc_nxt;
	logic        len_mm;

	assign sl      = sfb_pkg::clamp_len(cfg.start_flag_len, sfb_pkg::MAX_FLAG_BYTES);
	assign lb      = sfb_pkg::clamp_len(cfg.len_field_bytes, sfb_pkg::MAX_LEN_FIELD_BYTES);
	assign el      = sfb_pkg::clamp_len(cfg.end_flag_len, sfb_pkg::MAX_FLAG_BYTES);
	assign idx_inc = idx_q + 3'd1;
	assign len_k   = cfg.len_big_endian ? 3'(lb - 3'd1 - idx_q) : idx_q;
	assign cnt_inc = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;
	assign mism_now = (cnt_inc != head.payload_len);

	// output register frees up when empty or being taken
	assign load = head_valid && (!out_valid_q || framed.ready);

	always_comb begin
		if (phase_q == PH_BEGIN) begin
			if (!head.frame_first) begin
				eff = PH_DATA;
			end else if (sl != 3'd0) begin
				eff = PH_START;
			end else if (lb != 3'd0) begin
				eff = PH_LEN;
			end else begin
				eff = PH_DATA;
			end
		end else begin
			eff = phase_q;
		end
	end

	always_comb begin
		cur_byte = 8'h00;
		accum    = 1'b0;
		done     = 1'b0;
		nphase   = phase_q;
		nidx     = 3'd0;
		case (eff)
			PH_START: begin
				cur_byte = sfb_pkg::flag_byte(cfg.start_flag, idx_q);
				accum    = 1'b1;
				if (idx_inc < sl) begin
					nphase = PH_START;
					nidx   = idx_inc;
				end else begin
					nphase = (lb != 3'd0) ? PH_LEN : PH_DATA;
				end
			end
			PH_LEN: begin
				cur_byte = sfb_pkg::len_byte(head.payload_len, len_k);
				accum    = 1'b1;
				if (idx_inc < lb) begin
					nphase = PH_LEN;
					nidx   = idx_inc;
				end else begin
					nphase = PH_DATA;
				end
			end
			PH_DATA: begin
				cur_byte = head.data_byte;
				accum    = 1'b1;
				if (!head.frame_last) begin
					done = 1'b1;
				end else if (cfg.checksum_mode != sfb_pkg::CK_NONE) begin
					nphase = PH_CHK;
				end else if (el != 3'd0) begin
					nphase = PH_END;
				end else begin
					done = 1'b1;
				end
			end
			PH_CHK: begin
				// sum16 sends the high byte first
				if (cfg.checksum_mode == sfb_pkg::CK_SUM16 && idx_q == 3'd0) begin
					cur_byte = acc_q[15:8];
					nphase   = PH_CHK;
					nidx     = 3'd1;
				end else begin
					cur_byte = acc_q[7:0];
					if (el != 3'd0) begin
						nphase = PH_END;
					end else begin
						done = 1'b1;
					end
				end
			end
			PH_END: begin
				cur_byte = sfb_pkg::flag_byte(cfg.end_flag, idx_q);
				if (idx_inc < el) begin
					nphase = PH_END;
					nidx   = idx_inc;
				end else begin
					done = 1'b1;
				end
			end
			default: begin
				nphase = PH_BEGIN;
			end
		endcase
		if (done) begin
			nphase = PH_BEGIN;
			nidx   = 3'd0;
		end
	end

	assign frame_done = done && head.frame_last;
	assign len_mm     = frame_done && ((eff == PH_DATA) ? mism_now : mism_q);
	assign pop        = load && done;

	always_comb begin
		case (cfg.checksum_mode)
			sfb_pkg::CK_XOR:   acc_nxt = {8'h00, acc_q[7:0] ^ cur_byte};
			sfb_pkg::CK_SUM8:  acc_nxt = acc_q + {8'h00, cur_byte};
			sfb_pkg::CK_SUM16: acc_nxt = acc_q + {8'h00, cur_byte};
			default:           acc_nxt = acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_BEGIN;
			idx_q       <= 3'd0;
			acc_q       <= 16'h0000;
			cnt_q       <= 16'h0000;
			mism_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q <= nphase;
				idx_q   <= nidx;
				if (frame_done) begin
					acc_q <= 16'h0000;
					cnt_q <= 16'h0000;
				end else begin
					if (accum) begin
						acc_q <= acc_nxt;
					end
					if (eff == PH_DATA) begin
						cnt_q <= cnt_inc;
					end
				end
				if (eff == PH_DATA) begin
					mism_q <= mism_now;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (framed.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q     <= cur_byte;
			run_last_q     <= done;
			frame_end_q    <= frame_done;
			len_mismatch_q <= len_mm;
		end
	end

	assign framed.valid        = out_valid_q;
	assign framed.out_byte     = out_byte_q;
	assign framed.run_last     = run_last_q;
	assign framed.frame_end    = frame_end_q;
	assign framed.len_mismatch = len_mismatch_q;

	`SFB_ASSERT_IMPL(a_end_is_run_last, framed.valid && framed.frame_end, framed.run_last, "frame end without run last")
	`SFB_ASSERT_IMPL(a_mismatch_at_end, framed.valid && framed.len_mismatch, framed.frame_end, "length mismatch away from frame end")
	`SFB_ASSERT_IMPL(a_pop_needs_head, pop, head_valid, "pop from empty queue")
	`SFB_ASSERT_NEXT(a_clear_after_frame, load && frame_done, acc_q == 16'h0000 && cnt_q == 16'h0000 && phase_q == PH_BEGIN, "frame state not cleared at frame end")

endmodule

/* sv/serial_frame_builder_core.sv */
// top level of the serial frame builder: config registers, front, queue and back
//
// channel  modport  word fields
// payload  sink     data_byte[7:0] payload_len[15:0] frame_last
// framed   source   out_byte[7:0] run_last frame_end len_mismatch
// cfg      write    cfg_we cfg_index[2:0] cfg_data[31:0]
//
// a payload word inside a frame leaves one framed word
// the first word of a frame is preceded by its start flag and length bytes
// the last word is followed by its checksum bytes and end flag bytes
// the back sequencer emits one framed word per cycle unless the queue is empty
// or output stalls; the two-entry queue lets the front take words during a stall
// reset clears frame state and config, but sets len big-endian; no clearing pass
module serial_frame_builder_core (
	input  logic        clk,
	input  logic        arst_n,
	sfb_in_if.sink      payload,
	sfb_out_if.source   framed,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	sfb_pkg::sfb_cfg_t   cfg_q;
	sfb_pkg::sfb_entry_t push_entry;
	sfb_pkg::sfb_entry_t head;
	logic                push;
	logic                full;
	logic                pop;
	logic                head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_flag      <= 32'h0000_0000;
			cfg_q.start_flag_len  <= 3'd0;
			cfg_q.end_flag        <= 32'h0000_0000;
			cfg_q.end_flag_len    <= 3'd0;
			cfg_q.len_field_bytes <= 3'd0;
			cfg_q.len_big_endian  <= 1'b1;
			cfg_q.checksum_mode   <= sfb_pkg::CK_NONE;
		end else if (cfg_we) begin
			case (cfg_index)
				sfb_pkg::CFG_START_FLAG:      cfg_q.start_flag      <= cfg_data;
				sfb_pkg::CFG_START_FLAG_LEN:  cfg_q.start_flag_len  <= cfg_data[2:0];
				sfb_pkg::CFG_END_FLAG:        cfg_q.end_flag        <= cfg_data;
				sfb_pkg::CFG_END_FLAG_LEN:    cfg_q.end_flag_len    <= cfg_data[2:0];
				sfb_pkg::CFG_LEN_FIELD_BYTES: cfg_q.len_field_bytes <= cfg_data[2:0];
				sfb_pkg::CFG_LEN_BIG_ENDIAN:  cfg_q.len_big_endian  <= cfg_data[0];
				sfb_pkg::CFG_CHECKSUM_MODE:
					cfg_q.checksum_mode <= sfb_pkg::ck_mode_t'(cfg_data[1:0]);
				default: begin
				end
			endcase
		end
	end

	sfb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.payload (payload),
		.full    (full),
		.push    (push),
		.entry   (push_entry)
	);

	sfb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.entry_in   (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	sfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.framed     (framed)
	);

endmodule
